@@ sv/spd_pkg.sv @@
// Package: widths, constants, codes and shared types of the slotted page directory.
package spd_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int ENTRY_BYTES  = 4;
    localparam int MAX_SLOTS    = 32;

    localparam int BYTE_W = 13;
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    typedef logic [BYTE_W-1:0] t_bytes;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR   = 3'd0,
        K_INSERT  = 3'd1,
        K_READ    = 3'd2,
        K_DELETE  = 3'd3,
        K_COMPACT = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_LEN  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_DECIDE,
        S_WALK,
        S_PLACE,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_bytes offset;
        t_bytes length;
    } t_slot_entry;

    typedef struct packed {
        logic        re;
        t_slot       raddr;
        logic        we;
        t_slot       waddr;
        t_slot_entry wdata;
    } t_ram_req;

    typedef struct packed {
        t_status status;
        t_slot   slot;
        t_bytes  offset;
        t_bytes  size;
        logic    is_move;
        t_bytes  source;
        logic    last;
        t_bytes  free_bytes;
        t_count  slots_in_use;
    } t_result;

endpackage

@@ sv/slotted_page_directory.sv @@
// Top level of the slotted page directory.
//
//  channel   dir  transfer                tuser      tdata (low bit up)
//  i_s_*     in   one command             kind       record_length, slot_number
//  o_m_*     out  one result (tlast=end)  is_move    status, slot_number_out, rec_offset,
//                                                    record_size, move_source, free_bytes,
//                                                    slots_in_use
//
// One command at a time. Insert scans and the compaction walk use the single read port
// of the slot RAM, stepped one entry per cycle; the walk holds on an entry that moves
// until the output can take its move transfer.
// Synchronous active-low reset empties the page; the slot RAM needs no clearing pass.
// Output backpressure stalls the compaction walk per move transfer.
module slotted_page_directory (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [spd_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // record_length, slot_number
    input  logic [spd_pkg::KIND_W-1:0]          i_s_tuser,  // kind
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [spd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,  // status, slot_number_out,
                                                            // rec_offset, record_size,
                                                            // move_source, free_bytes,
                                                            // slots_in_use
    output logic                                o_m_tuser,  // is_move
    output logic                                o_m_tlast
);
    import spd_pkg::*;

    t_ram_req         ram_req;
    logic [$bits(t_slot_entry)-1:0] ram_rdata;
    logic             push;
    t_result          result;
    logic             out_free;

    spd_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH ($bits(t_slot_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    spd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_kind      (t_kind'(i_s_tuser)),
        .i_len       (i_s_tdata[BYTE_W-1:0]),
        .i_sn        (i_s_tdata[BYTE_W+SLOT_W-1:BYTE_W]),
        .o_ram       (ram_req),
        .i_ram_rdata (t_slot_entry'(ram_rdata)),
        .o_push      (push),
        .o_result    (result),
        .i_out_free  (out_free)
    );

    spd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (result),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ sv/spd_slot_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered read data.
module spd_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/spd_out_stage.sv @@
// Output register of the result stream, with tdata packing.
module spd_out_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  spd_pkg::t_result                    i_result,
    output logic                                o_free,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [spd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    import spd_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - STAT_W - SLOT_W - 4 * BYTE_W - CNT_W;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_data <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_data.is_move;
    assign o_m_tlast  = r_data.last;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_data.slots_in_use, r_data.free_bytes,
                         r_data.source, r_data.size, r_data.offset, r_data.slot,
                         r_data.status};

endmodule

@@ sv/spd_ctrl.sv @@
// Sequencer: directory scans, compaction walk and bookkeeping of the page bounds.
module spd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  spd_pkg::t_kind        i_kind,
    input  spd_pkg::t_bytes       i_len,
    input  spd_pkg::t_slot        i_sn,
    output spd_pkg::t_ram_req     o_ram,
    input  spd_pkg::t_slot_entry  i_ram_rdata,
    output logic                  o_push,
    output spd_pkg::t_result      o_result,
    input  logic                  i_out_free
);
    import spd_pkg::*;

    t_state  r_state, n_state;
    t_count  r_total, n_total;
    t_bytes  r_fstart, n_fstart;
    t_bytes  r_fend, n_fend;
    t_bytes  r_frag, n_frag;
    t_count  r_idx, n_idx;
    t_kind   r_kind, n_kind;
    t_bytes  r_len, n_len;
    t_slot   r_sn, n_sn;
    logic    r_reuse, n_reuse;
    t_slot   r_slot, n_slot;
    logic    r_after_ins, n_after_ins;
    t_bytes  r_new_end, n_new_end;
    t_bytes  r_fb_final, n_fb_final;
    t_count  r_total_final, n_total_final;
    t_result r_res, n_res;

    t_bytes            contig;
    logic [BYTE_W:0]   avail_tot;
    logic [BYTE_W:0]   needed;
    t_count            idx_next;
    t_bytes            dest;
    t_bytes            walk_end;
    t_slot             place_slot;

    assign contig    = (r_fend > r_fstart) ? (r_fend - r_fstart) : '0;
    assign avail_tot = {1'b0, contig} + {1'b0, r_frag};
    assign needed    = {1'b0, r_len} + (r_reuse ? '0 : (BYTE_W + 1)'(ENTRY_BYTES));
    assign idx_next  = r_idx + 1'b1;
    assign dest      = (i_ram_rdata.length <= r_new_end) ?
                       (r_new_end - i_ram_rdata.length) : '0;
    assign walk_end  = (i_ram_rdata.length != '0) ? dest : r_new_end;
    assign place_slot = r_reuse ? r_slot : r_total[SLOT_W-1:0];

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_total       = r_total;
        n_fstart      = r_fstart;
        n_fend        = r_fend;
        n_frag        = r_frag;
        n_idx         = r_idx;
        n_kind        = r_kind;
        n_len         = r_len;
        n_sn          = r_sn;
        n_reuse       = r_reuse;
        n_slot        = r_slot;
        n_after_ins   = r_after_ins;
        n_new_end     = r_new_end;
        n_fb_final    = r_fb_final;
        n_total_final = r_total_final;
        n_res         = r_res;
        o_ram         = '0;
        o_push        = 1'b0;
        o_result      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_len   = i_len;
                    n_sn    = i_sn;
                    n_reuse = 1'b0;
                    n_res   = '0;
                    unique case (i_kind)
                        K_CLEAR: begin
                            n_total  = '0;
                            n_fstart = BYTE_W'(HEADER_BYTES);
                            n_fend   = BYTE_W'(PAGE_BYTES);
                            n_frag   = '0;
                            n_state  = S_EMIT;
                        end
                        K_INSERT: begin
                            if (i_len == '0) begin
                                n_res.status = ST_ZERO_LEN;
                                n_state      = S_EMIT;
                            end else if (r_total == '0) begin
                                n_state = S_DECIDE;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        K_READ, K_DELETE: begin
                            if ({1'b0, i_sn} >= r_total) begin
                                n_res.status = ST_NOT_FOUND;
                                n_res.slot   = i_sn;
                                n_state      = S_EMIT;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = i_sn;
                                n_state     = S_LOOKUP;
                            end
                        end
                        K_COMPACT: begin
                            n_after_ins = 1'b0;
                            if (r_frag == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                // Fragmented bytes imply at least one slot.
                                n_fb_final    = BYTE_W'(avail_tot);
                                n_total_final = r_total;
                                n_new_end     = BYTE_W'(PAGE_BYTES);
                                n_idx         = '0;
                                o_ram.re      = 1'b1;
                                o_ram.raddr   = '0;
                                n_state       = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_LOOKUP: begin
                n_res.slot = r_sn;
                if (i_ram_rdata.length != '0) begin
                    n_res.status = ST_OK;
                    n_res.offset = i_ram_rdata.offset;
                    n_res.size   = i_ram_rdata.length;
                    if (r_kind == K_DELETE) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_sn;
                        o_ram.wdata = '0;
                        n_frag      = r_frag + i_ram_rdata.length;
                    end
                end else begin
                    n_res.status = ST_NOT_FOUND;
                end
                n_state = S_EMIT;
            end

            S_SCAN: begin
                // Read of the next entry overlaps the check of this one.
                if (i_ram_rdata.length == '0) begin
                    n_reuse = 1'b1;
                    n_slot  = r_idx[SLOT_W-1:0];
                    n_state = S_DECIDE;
                end else if (idx_next == r_total) begin
                    n_state = S_DECIDE;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = idx_next[SLOT_W-1:0];
                    n_idx       = idx_next;
                end
            end

            S_DECIDE: begin
                if (!r_reuse && r_total >= CNT_W'(MAX_SLOTS)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_EMIT;
                end else if ({1'b0, contig} >= needed) begin
                    n_state = S_PLACE;
                end else if (avail_tot >= needed) begin
                    // Compaction keeps the total free space, so the final
                    // figures are known before the walk starts.
                    n_after_ins   = 1'b1;
                    n_fb_final    = BYTE_W'(avail_tot - needed);
                    n_total_final = r_reuse ? r_total : (r_total + 1'b1);
                    n_new_end     = BYTE_W'(PAGE_BYTES);
                    n_idx         = '0;
                    o_ram.re      = 1'b1;
                    o_ram.raddr   = '0;
                    n_state       = S_WALK;
                end else begin
                    n_res.status = ST_FULL;
                    n_state      = S_EMIT;
                end
            end

            S_WALK: begin
                // Write-back of this entry and read of the next never share an address.
                if (i_ram_rdata.length == '0 || i_out_free) begin
                    if (i_ram_rdata.length != '0) begin
                        o_push                = 1'b1;
                        o_result.status       = ST_OK;
                        o_result.slot         = r_idx[SLOT_W-1:0];
                        o_result.offset       = dest;
                        o_result.size         = i_ram_rdata.length;
                        o_result.is_move      = 1'b1;
                        o_result.source       = i_ram_rdata.offset;
                        o_result.last         = 1'b0;
                        o_result.free_bytes   = r_fb_final;
                        o_result.slots_in_use = r_total_final;
                        o_ram.we              = 1'b1;
                        o_ram.waddr           = r_idx[SLOT_W-1:0];
                        o_ram.wdata.offset    = dest;
                        o_ram.wdata.length    = i_ram_rdata.length;
                    end
                    n_new_end = walk_end;
                    if (idx_next == r_total) begin
                        n_fend  = walk_end;
                        n_frag  = '0;
                        n_state = r_after_ins ? S_PLACE : S_EMIT;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = idx_next[SLOT_W-1:0];
                        n_idx       = idx_next;
                    end
                end
            end

            S_PLACE: begin
                n_fend = r_fend - r_len;
                if (!r_reuse) begin
                    n_total  = r_total + 1'b1;
                    n_fstart = r_fstart + BYTE_W'(ENTRY_BYTES);
                end
                o_ram.we           = 1'b1;
                o_ram.waddr        = place_slot;
                o_ram.wdata.offset = r_fend - r_len;
                o_ram.wdata.length = r_len;
                n_res.status       = ST_OK;
                n_res.slot         = place_slot;
                n_res.offset       = r_fend - r_len;
                n_res.size         = r_len;
                n_state            = S_EMIT;
            end

            S_EMIT: begin
                o_result              = r_res;
                o_result.last         = 1'b1;
                o_result.free_bytes   = contig + r_frag;
                o_result.slots_in_use = r_total;
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_fstart <= BYTE_W'(HEADER_BYTES);
            r_fend   <= BYTE_W'(PAGE_BYTES);
            r_frag   <= '0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_fstart <= n_fstart;
            r_fend   <= n_fend;
            r_frag   <= n_frag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_kind        <= n_kind;
        r_len         <= n_len;
        r_sn          <= n_sn;
        r_reuse       <= n_reuse;
        r_slot        <= n_slot;
        r_after_ins   <= n_after_ins;
        r_new_end     <= n_new_end;
        r_fb_final    <= n_fb_final;
        r_total_final <= n_total_final;
        r_res         <= n_res;
    end

endmodule
